@@ hw/rtl/phdp_pkg.sv @@
// ----------------------------------------------------------------------------
// phdp_pkg
// Shared types, register indexes and constants of the drift projection block.
// ----------------------------------------------------------------------------
package phdp_pkg;

   localparam int POS_W   = 24;
   localparam int DIR_W   = 16;
   localparam int THICK_W = 16;
   localparam int ROW_W   = 48;
   localparam int IDX_W   = 3;
   localparam int DATA_W  = 48;
   localparam int DIR_FRAC = 14;
   // positions are Q13.10; rounding is set by the Q1.14 rotation entries
   localparam int POS_FRAC_BITS = 10;

   typedef enum logic [IDX_W-1:0] {
      REG_ROT_ROW_X   = 3'd0,
      REG_ROT_ROW_Y   = 3'd1,
      REG_ROT_ROW_Z   = 3'd2,
      REG_ORIGIN_X    = 3'd3,
      REG_ORIGIN_Y    = 3'd4,
      REG_ORIGIN_Z    = 3'd5,
      REG_THICKNESS   = 3'd6,
      REG_DRIFT       = 3'd7
   } reg_index_type;

   localparam logic signed [POS_W-1:0] OUT_MAX = 24'sh7FFFFF;
   localparam logic signed [POS_W-1:0] OUT_MIN = -24'sh800000;

   // saturate a wide signed value to the 24-bit output range
   function automatic logic signed [POS_W-1:0] sat24(input logic signed [63:0] v);
      logic signed [POS_W-1:0] r;
      if (v > 64'sd8388607) begin
         r = OUT_MAX;
      end else if (v < -64'sd8388608) begin
         r = OUT_MIN;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/phdp_divider.sv @@
// ----------------------------------------------------------------------------
// phdp_divider
// Pipelined signed divider, round to nearest, ties away from zero.
// One quotient bit per stage; a new operand pair may enter every cycle.
// ----------------------------------------------------------------------------
module phdp_divider #(
   parameter int NUM_W = 34,
   parameter int DEN_W = 18,
   parameter int TAG_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [NUM_W-1:0] in_num,
   input  logic signed [DEN_W-1:0] in_den,
   input  logic        [TAG_W-1:0] in_tag,
   output logic                    out_valid,
   output logic signed [NUM_W:0]   out_quo,
   output logic        [TAG_W-1:0] out_tag
);
   // |num| + |den|/2 fits NUM_W+1 bits unsigned
   localparam int QW = NUM_W + 1;
   localparam int DW = DEN_W;

   logic             v_ff   [0:QW];
   logic [QW-1:0]    rem_ff [0:QW];
   logic [QW-1:0]    q_ff   [0:QW];
   logic [DW-1:0]    d_ff   [0:QW];
   logic             neg_ff [0:QW];
   logic             z_ff   [0:QW];
   logic [TAG_W-1:0] tag_ff [0:QW];

   logic [QW-1:0] un;
   logic [DW-1:0] ud;

   always_comb begin
      un = in_num[NUM_W-1] ? QW'(-in_num) : QW'(in_num);
      ud = in_den[DEN_W-1] ? DW'(-in_den) : DW'(in_den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QW; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else begin
         v_ff[0] <= in_valid;
         for (int s = 1; s <= QW; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= un + QW'(ud >> 1);
      q_ff[0]   <= '0;
      d_ff[0]   <= ud;
      neg_ff[0] <= in_num[NUM_W-1] ^ in_den[DEN_W-1];
      z_ff[0]   <= (ud == '0);
      tag_ff[0] <= in_tag;
      for (int s = 1; s <= QW; s++) begin
         // restoring step on bit QW-s
         if ((rem_ff[s-1] >> (QW - s)) >= (QW)'(d_ff[s-1])) begin
            rem_ff[s] <= rem_ff[s-1] - ((QW)'(d_ff[s-1]) << (QW - s));
            q_ff[s]   <= q_ff[s-1] | (QW'(1) << (QW - s));
         end else begin
            rem_ff[s] <= rem_ff[s-1];
            q_ff[s]   <= q_ff[s-1];
         end
         d_ff[s]   <= d_ff[s-1];
         neg_ff[s] <= neg_ff[s-1];
         z_ff[s]   <= z_ff[s-1];
         tag_ff[s] <= tag_ff[s-1];
      end
   end

   // quotient magnitude stays below 2^(QW-1), so its top bit is clear
   always_comb begin
      out_valid = v_ff[QW];
      out_tag   = tag_ff[QW];
      if (z_ff[QW]) begin
         out_quo = '0;
      end else if (neg_ff[QW]) begin
         out_quo = -$signed(q_ff[QW]);
      end else begin
         out_quo = $signed(q_ff[QW]);
      end
   end
endmodule

@@ hw/rtl/planar_hit_drift_projection.sv @@
// ----------------------------------------------------------------------------
// planar_hit_drift_projection
// Carries a global hit and direction into a sensor frame, gives entry/exit
// points across the sensor thickness and their drift-shifted x,y.
// ----------------------------------------------------------------------------
//  channel | ports            | transfer when
//  --------+------------------+------------------------------
//  request | req_start/busy   | req_start && !req_busy
//  result  | rsp_valid        | rsp_valid (one cycle, no stall)
//  config  | csr_valid/ready  | csr_valid && csr_ready
//
// The datapath holds 59 register stages: s1-s4, the 53-stage divider
// (one per quotient bit of the 52-bit quotient, plus its input stage), s5
// and the output register. One hit enters per cycle; req_busy is never
// high, since the receiver cannot stall and nothing inside ever waits.
// Reset clears the valid bits and loads the identity rotation, zero origin,
// thickness 307 and zero drift. The user must rewrite registers only while
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module planar_hit_drift_projection #(
   parameter int EPSILON_Q     = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_start,
   output logic                               req_busy,
   input  logic signed [phdp_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [phdp_pkg::POS_W-1:0]  req_pos_y,
   input  logic signed [phdp_pkg::POS_W-1:0]  req_pos_z,
   input  logic signed [phdp_pkg::DIR_W-1:0]  req_dir_x,
   input  logic signed [phdp_pkg::DIR_W-1:0]  req_dir_y,
   input  logic signed [phdp_pkg::DIR_W-1:0]  req_dir_z,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [phdp_pkg::IDX_W-1:0]         csr_index,
   input  logic [phdp_pkg::DATA_W-1:0]        csr_data,
   output logic                               rsp_valid,
   output logic signed [phdp_pkg::POS_W-1:0]  rsp_drifted_entry_x,
   output logic signed [phdp_pkg::POS_W-1:0]  rsp_drifted_entry_y,
   output logic signed [phdp_pkg::POS_W-1:0]  rsp_drifted_exit_x,
   output logic signed [phdp_pkg::POS_W-1:0]  rsp_drifted_exit_y,
   output logic signed [phdp_pkg::POS_W-1:0]  rsp_entry_x,
   output logic signed [phdp_pkg::POS_W-1:0]  rsp_entry_y,
   output logic signed [phdp_pkg::POS_W-1:0]  rsp_entry_z,
   output logic signed [phdp_pkg::POS_W-1:0]  rsp_exit_x,
   output logic signed [phdp_pkg::POS_W-1:0]  rsp_exit_y,
   output logic signed [phdp_pkg::POS_W-1:0]  rsp_exit_z,
   output logic                               rsp_parallel_error
);
   import phdp_pkg::*;

   // rotation sums are rounded at the Q1.14 point of the rotation entries
   localparam int RND = 1 << (DIR_FRAC - 1);
   localparam logic [63:0] EPS  = 64'(EPSILON_Q);
   localparam logic [63:0] EPS2 = 64'(EPSILON_Q * EPSILON_Q);

   // ---------------- configuration registers ----------------
   logic [ROW_W-1:0]         rot_ff [0:2];
   logic signed [POS_W-1:0]  org_ff [0:2];
   logic [THICK_W-1:0]       thick_ff;
   logic [ROW_W-1:0]         drift_ff;

   assign csr_ready = 1'b1;
   assign req_busy  = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= 48'd16384;
         rot_ff[1] <= 48'd16384 << 16;
         rot_ff[2] <= 48'd16384 << 32;
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         thick_ff  <= 16'd307;
         drift_ff  <= '0;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_ROT_ROW_X: rot_ff[0] <= csr_data;
            REG_ROT_ROW_Y: rot_ff[1] <= csr_data;
            REG_ROT_ROW_Z: rot_ff[2] <= csr_data;
            REG_ORIGIN_X:  org_ff[0] <= csr_data[POS_W-1:0];
            REG_ORIGIN_Y:  org_ff[1] <= csr_data[POS_W-1:0];
            REG_ORIGIN_Z:  org_ff[2] <= csr_data[POS_W-1:0];
            REG_THICKNESS: thick_ff  <= csr_data[THICK_W-1:0];
            REG_DRIFT:     drift_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   function automatic logic signed [DIR_W-1:0] lane(input logic [ROW_W-1:0] p,
                                                    input int k);
      return $signed(p[16*k +: 16]);
   endfunction

   // drift offsets only depend on configuration: constant while items flow
   logic signed [DIR_W-1:0] vx, vy, vz;
   logic                    drift_on;
   always_comb begin
      vx = lane(drift_ff, 0);
      vy = lane(drift_ff, 1);
      vz = lane(drift_ff, 2);
      drift_on = (64'(33'(32'(vx) * 32'(vx)) + 33'(32'(vy) * 32'(vy))) > EPS2) &&
                 ($signed(vz < 0 ? -17'(vz) : 17'(vz)) > $signed(17'(EPS)));
   end

   // ---------------- s1: relative position ----------------
   logic                    s1_v_ff;
   logic signed [POS_W:0]   s1_rel_ff [0:2];
   logic signed [DIR_W-1:0] s1_dir_ff [0:2];
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else       s1_v_ff <= req_start;
      s1_rel_ff[0] <= 25'(req_pos_x) - 25'(org_ff[0]);
      s1_rel_ff[1] <= 25'(req_pos_y) - 25'(org_ff[1]);
      s1_rel_ff[2] <= 25'(req_pos_z) - 25'(org_ff[2]);
      s1_dir_ff[0] <= req_dir_x;
      s1_dir_ff[1] <= req_dir_y;
      s1_dir_ff[2] <= req_dir_z;
   end

   // ---------------- s2: products ----------------
   logic                 s2_v_ff;
   logic signed [40:0]   s2_pp_ff [0:2][0:2];
   logic signed [31:0]   s2_pd_ff [0:2][0:2];
   logic [31:0]          s2_dd_ff [0:2];
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else       s2_v_ff <= s1_v_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s2_pp_ff[i][j] <= 41'(lane(rot_ff[i], j)) * 41'(s1_rel_ff[j]);
            s2_pd_ff[i][j] <= 32'(lane(rot_ff[i], j)) * 32'(s1_dir_ff[j]);
         end
         s2_dd_ff[i] <= 32'(32'(s1_dir_ff[i]) * 32'(s1_dir_ff[i]));
      end
   end

   // ---------------- s3: sums, rounding ----------------
   logic               s3_v_ff;
   logic signed [29:0] s3_lp_ff [0:2];
   logic signed [33:0] s3_ld_ff [0:2];
   logic [33:0]        s3_d2_ff;
   always_ff @(posedge clock) begin
      logic signed [42:0] sp;
      if (reset) s3_v_ff <= 1'b0;
      else       s3_v_ff <= s2_v_ff;
      for (int i = 0; i < 3; i++) begin
         sp = 43'(s2_pp_ff[i][0]) + 43'(s2_pp_ff[i][1]) + 43'(s2_pp_ff[i][2])
              + 43'(RND);
         s3_lp_ff[i] <= 30'(sp >>> DIR_FRAC);
         s3_ld_ff[i] <= 34'(s2_pd_ff[i][0]) + 34'(s2_pd_ff[i][1])
                        + 34'(s2_pd_ff[i][2]);
      end
      s3_d2_ff <= 34'(s2_dd_ff[0]) + 34'(s2_dd_ff[1]) + 34'(s2_dd_ff[2]);
   end

   // ---------------- s4: parallel test, divider operands ----------------
   logic               s4_v_ff, s4_par_ff;
   logic [67:0]        s4_dz2_ff, s4_lim_ff;
   logic signed [29:0] s4_lp_ff [0:2];
   logic signed [50:0] s4_num_ff [0:2];
   logic signed [34:0] s4_den_ff;
   logic [33:0]        az;
   always_comb az = s3_ld_ff[2][33] ? 34'(-s3_ld_ff[2]) : 34'(s3_ld_ff[2]);
   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else       s4_v_ff <= s3_v_ff;
      s4_dz2_ff <= 68'(az) * 68'(az);
      s4_lim_ff <= 68'(EPS2) * 68'(s3_d2_ff);
      s4_par_ff <= (s3_ld_ff[2] == '0);
      for (int i = 0; i < 3; i++) begin
         s4_lp_ff[i]  <= s3_lp_ff[i];
         s4_num_ff[i] <= 51'($signed({1'b0, thick_ff})) * 51'(s3_ld_ff[i]);
      end
      s4_den_ff <= 35'(s3_ld_ff[2]) <<< 1;
   end

   // ---------------- dividers: half segment per axis ----------------
   localparam int TAG_W = 1 + 3 * 30;
   logic [TAG_W-1:0] tag_in;
   assign tag_in = {s4_par_ff || (s4_dz2_ff < s4_lim_ff),
                    s4_lp_ff[2], s4_lp_ff[1], s4_lp_ff[0]};

   logic                 dv_v [0:2];
   logic signed [51:0]   dv_q [0:2];
   logic [TAG_W-1:0]     dv_t [0:2];

   for (genvar g = 0; g < 3; g++) begin : g_div
      phdp_divider #(.NUM_W(51), .DEN_W(35), .TAG_W(TAG_W)) u_div (
         .clock    (clock),
         .reset    (reset),
         .in_valid (s4_v_ff),
         .in_num   (s4_num_ff[g]),
         .in_den   (s4_den_ff),
         .in_tag   (tag_in),
         .out_valid(dv_v[g]),
         .out_quo  (dv_q[g]),
         .out_tag  (dv_t[g])
      );
   end

   // drift offsets: configuration-only divisions, same divider depth
   logic signed [51:0] ox_q, oy_q;
   logic               ox_v, oy_v;
   logic               ox_t, oy_t;
   phdp_divider #(.NUM_W(51), .DEN_W(35), .TAG_W(1)) u_ox (
      .clock(clock), .reset(reset), .in_valid(s4_v_ff),
      .in_num(51'($signed({1'b0, thick_ff})) * 51'(vx)),
      .in_den(35'(vz) <<< 1), .in_tag(drift_on),
      .out_valid(ox_v), .out_quo(ox_q), .out_tag(ox_t));
   phdp_divider #(.NUM_W(51), .DEN_W(35), .TAG_W(1)) u_oy (
      .clock(clock), .reset(reset), .in_valid(s4_v_ff),
      .in_num(51'($signed({1'b0, thick_ff})) * 51'(vy)),
      .in_den(35'(vz) <<< 1), .in_tag(drift_on),
      .out_valid(oy_v), .out_quo(oy_q), .out_tag(oy_t));

   // ---------------- s5: entry/exit ----------------
   logic               s5_v_ff, s5_par_ff, s5_drift_ff;
   logic signed [53:0] s5_ent_ff [0:2];
   logic signed [53:0] s5_ext_ff [0:2];
   logic signed [51:0] s5_ox_ff, s5_oy_ff;
   always_ff @(posedge clock) begin
      if (reset) s5_v_ff <= 1'b0;
      else       s5_v_ff <= dv_v[0] && dv_v[1] && dv_v[2] && ox_v && oy_v;
      s5_par_ff   <= dv_t[0][TAG_W-1];
      s5_drift_ff <= ox_t && oy_t;
      s5_ox_ff    <= ox_q;
      s5_oy_ff    <= oy_q;
      for (int i = 0; i < 3; i++) begin
         s5_ent_ff[i] <= 54'($signed(dv_t[0][30*i +: 30])) - 54'(dv_q[i]);
         s5_ext_ff[i] <= 54'($signed(dv_t[0][30*i +: 30])) + 54'(dv_q[i]);
      end
   end

   // ---------------- s6: drift, saturate, output register ----------------
   logic signed [54:0] dex, dey, dxx, dxy;
   always_comb begin
      dex = 55'(s5_ent_ff[0]);
      dey = 55'(s5_ent_ff[1]);
      dxx = 55'(s5_ext_ff[0]);
      dxy = 55'(s5_ext_ff[1]);
      if (s5_drift_ff) begin
         dex = dex + 55'(s5_ox_ff);
         dey = dey + 55'(s5_oy_ff);
         dxx = dxx - 55'(s5_ox_ff);
         dxy = dxy - 55'(s5_oy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= s5_v_ff;
      if (s5_par_ff) begin
         rsp_drifted_entry_x <= '0;
         rsp_drifted_entry_y <= '0;
         rsp_drifted_exit_x  <= '0;
         rsp_drifted_exit_y  <= '0;
         rsp_entry_x <= '0;
         rsp_entry_y <= '0;
         rsp_entry_z <= '0;
         rsp_exit_x  <= '0;
         rsp_exit_y  <= '0;
         rsp_exit_z  <= '0;
      end else begin
         rsp_drifted_entry_x <= sat24(64'(dex));
         rsp_drifted_entry_y <= sat24(64'(dey));
         rsp_drifted_exit_x  <= sat24(64'(dxx));
         rsp_drifted_exit_y  <= sat24(64'(dxy));
         rsp_entry_x <= sat24(64'(s5_ent_ff[0]));
         rsp_entry_y <= sat24(64'(s5_ent_ff[1]));
         rsp_entry_z <= sat24(64'(s5_ent_ff[2]));
         rsp_exit_x  <= sat24(64'(s5_ext_ff[0]));
         rsp_exit_y  <= sat24(64'(s5_ext_ff[1]));
         rsp_exit_z  <= sat24(64'(s5_ext_ff[2]));
      end
      rsp_parallel_error <= s5_par_ff;
   end
endmodule

@@ hw/rtl/phdp_checker.sv @@
// ----------------------------------------------------------------------------
// phdp_checker
// Port-level checks of the drift projection block, bound to its top level.
// ----------------------------------------------------------------------------
module phdp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_busy,
   input logic                       csr_ready,
   input logic                       rsp_valid,
   input logic                       rsp_parallel_error,
   input logic signed [23:0]         rsp_entry_x,
   input logic signed [23:0]         rsp_exit_z,
   input logic signed [23:0]         rsp_drifted_exit_y
);
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !req_busy)
      else $error("block stalled requests");
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("config port not ready");
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result right after reset");
   a_par_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parallel_error |->
         rsp_entry_x == 24'sd0 && rsp_exit_z == 24'sd0 && rsp_drifted_exit_y == 24'sd0)
      else $error("parallel result carries nonzero fields");
endmodule

bind planar_hit_drift_projection phdp_checker u_phdp_checker (
   .clock(clock), .reset(reset), .req_busy(req_busy), .csr_ready(csr_ready),
   .rsp_valid(rsp_valid), .rsp_parallel_error(rsp_parallel_error),
   .rsp_entry_x(rsp_entry_x), .rsp_exit_z(rsp_exit_z),
   .rsp_drifted_exit_y(rsp_drifted_exit_y)
);

@@ bench/planar_hit_drift_projection_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// planar_hit_drift_projection_checker
// Watches the hit, result and register channels of the projection block,
// keeps its own copy of the sensor registers, predicts every result and
// compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module planar_hit_drift_projection_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_start,
   input  logic                               req_busy,
   input  logic signed [phdp_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [phdp_pkg::POS_W-1:0]  req_pos_y,
   input  logic signed [phdp_pkg::POS_W-1:0]  req_pos_z,
   input  logic signed [phdp_pkg::DIR_W-1:0]  req_dir_x,
   input  logic signed [phdp_pkg::DIR_W-1:0]  req_dir_y,
   input  logic signed [phdp_pkg::DIR_W-1:0]  req_dir_z,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [phdp_pkg::IDX_W-1:0]         csr_index,
   input  logic [phdp_pkg::DATA_W-1:0]        csr_data,
   input  logic                               rsp_valid,
   input  logic signed [phdp_pkg::POS_W-1:0]  rsp_drifted_entry_x,
   input  logic signed [phdp_pkg::POS_W-1:0]  rsp_drifted_entry_y,
   input  logic signed [phdp_pkg::POS_W-1:0]  rsp_drifted_exit_x,
   input  logic signed [phdp_pkg::POS_W-1:0]  rsp_drifted_exit_y,
   input  logic signed [phdp_pkg::POS_W-1:0]  rsp_entry_x,
   input  logic signed [phdp_pkg::POS_W-1:0]  rsp_entry_y,
   input  logic signed [phdp_pkg::POS_W-1:0]  rsp_entry_z,
   input  logic signed [phdp_pkg::POS_W-1:0]  rsp_exit_x,
   input  logic signed [phdp_pkg::POS_W-1:0]  rsp_exit_y,
   input  logic signed [phdp_pkg::POS_W-1:0]  rsp_exit_z,
   input  logic                               rsp_parallel_error,
   output int                                 failures,
   output int                                 pending
);
   import phdp_pkg::*;

   localparam longint EPS = 1;

   typedef struct {
      longint pt[10];   // drifted entry x,y, drifted exit x,y, entry xyz, exit xyz
      logic   perr;
   } projection_type;

   logic [ROW_W-1:0]         row_x, row_y, row_z, drift;
   logic signed [POS_W-1:0]  org_x, org_y, org_z;
   logic [THICK_W-1:0]       thick;
   projection_type           expected_q[$];

   function automatic longint lane_of(logic [ROW_W-1:0] p, int k);
      logic signed [15:0] s;
      s = p[16*k +: 16];
      return longint'(s);
   endfunction

   // nearest, ties away from zero
   function automatic longint round_div(longint num, longint den);
      longint unsigned un, ud, q;
      if (den == 0) begin
         return 0;
      end
      un = (num < 0) ? longint'(-num) : num;
      ud = (den < 0) ? longint'(-den) : den;
      q  = (un + ud / 2) / ud;
      return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clip24(longint v);
      if (v > 64'sd8388607) begin
         return 64'sd8388607;
      end
      if (v < -64'sd8388608) begin
         return -64'sd8388608;
      end
      return v;
   endfunction

   function automatic projection_type project_hit(longint px, longint py, longint pz,
                                                  longint dx, longint dy, longint dz);
      projection_type     r;
      logic [ROW_W-1:0]   rows[3];
      longint             rel[3], dv[3], lp[3], ld[3], h[3], ent[3], ext[3], v[3];
      longint             sp, sd, t, ox, oy, az;
      longint unsigned    d2, dz2, azu;
      rows[0] = row_x; rows[1] = row_y; rows[2] = row_z;
      rel[0] = px - longint'(org_x);
      rel[1] = py - longint'(org_y);
      rel[2] = pz - longint'(org_z);
      dv[0] = dx; dv[1] = dy; dv[2] = dz;
      t = longint'(thick);
      for (int i = 0; i < 3; i++) begin
         sp = 0;
         sd = 0;
         for (int j = 0; j < 3; j++) begin
            sp += lane_of(rows[i], j) * rel[j];
            sd += lane_of(rows[i], j) * dv[j];
         end
         lp[i] = (sp + (64'sd1 <<< (DIR_FRAC - 1))) >>> DIR_FRAC;
         ld[i] = sd;
      end
      for (int i = 0; i < 10; i++) begin
         r.pt[i] = 0;
      end
      r.perr = 1'b0;
      d2  = dx * dx + dy * dy + dz * dz;
      azu = (ld[2] < 0) ? longint'(-ld[2]) : ld[2];
      dz2 = azu * azu;
      // too shallow a crossing: flag only, all points zero
      if (ld[2] == 0 || dz2 < EPS * EPS * d2) begin
         r.perr = 1'b1;
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         h[i]   = round_div(t * ld[i], 2 * ld[2]);
         ent[i] = lp[i] - h[i];
         ext[i] = lp[i] + h[i];
      end
      for (int i = 0; i < 3; i++) begin
         v[i] = lane_of(drift, i);
      end
      r.pt[0] = ent[0]; r.pt[1] = ent[1];
      r.pt[2] = ext[0]; r.pt[3] = ext[1];
      az = (v[2] < 0) ? -v[2] : v[2];
      if (v[0] * v[0] + v[1] * v[1] > EPS * EPS && az > EPS) begin
         ox = round_div(t * v[0], 2 * v[2]);
         oy = round_div(t * v[1], 2 * v[2]);
         r.pt[0] += ox; r.pt[1] += oy;
         r.pt[2] -= ox; r.pt[3] -= oy;
      end
      r.pt[4] = ent[0]; r.pt[5] = ent[1]; r.pt[6] = ent[2];
      r.pt[7] = ext[0]; r.pt[8] = ext[1]; r.pt[9] = ext[2];
      for (int i = 0; i < 10; i++) begin
         r.pt[i] = clip24(r.pt[i]);
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $time, field, got, want);
      failures++;
   endtask

   initial begin
      failures = 0;
   end

   always @(posedge clock) begin
      projection_type want;
      longint         got[10];
      if (reset) begin
         row_x <= 48'd16384;
         row_y <= 48'd16384 << 16;
         row_z <= 48'd16384 << 32;
         org_x <= '0;
         org_y <= '0;
         org_z <= '0;
         thick <= 16'd307;
         drift <= '0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_ROT_ROW_X: row_x <= csr_data;
               REG_ROT_ROW_Y: row_y <= csr_data;
               REG_ROT_ROW_Z: row_z <= csr_data;
               REG_ORIGIN_X:  org_x <= csr_data[POS_W-1:0];
               REG_ORIGIN_Y:  org_y <= csr_data[POS_W-1:0];
               REG_ORIGIN_Z:  org_z <= csr_data[POS_W-1:0];
               REG_THICKNESS: thick <= csr_data[THICK_W-1:0];
               REG_DRIFT:     drift <= csr_data;
               default: ;
            endcase
         end
         if (req_start && !req_busy) begin
            expected_q.push_back(project_hit(req_pos_x, req_pos_y, req_pos_z,
                                             req_dir_x, req_dir_y, req_dir_z));
         end
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = expected_q.pop_front();
               got = '{rsp_drifted_entry_x, rsp_drifted_entry_y, rsp_drifted_exit_x,
                       rsp_drifted_exit_y, rsp_entry_x, rsp_entry_y, rsp_entry_z,
                       rsp_exit_x, rsp_exit_y, rsp_exit_z};
               for (int i = 0; i < 10; i++) begin
                  if (got[i] != want.pt[i]) begin
                     report_mismatch($sformatf("point field %0d", i), got[i], want.pt[i]);
                  end
               end
               if (rsp_parallel_error !== want.perr) begin
                  report_mismatch("parallel_error", rsp_parallel_error, want.perr);
               end
            end
         end
      end
   end

   assign pending = expected_q.size();

endmodule

@@ bench/planar_hit_drift_projection_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// planar_hit_drift_projection_test
// Drives hits through the projection block over a series of sensor
// geometries and drift settings; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module planar_hit_drift_projection_test;
   import phdp_pkg::*;

   localparam int IDLE_LIMIT = 5000;   // cycles with no transfer at all
   localparam int SETTLE     = 80;     // covers the pipeline depth
   localparam int PHASE_HITS = 250;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_start = 1'b0;
   logic signed [POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [DIR_W-1:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic                    csr_valid = 1'b0;
   logic [IDX_W-1:0]        csr_index = '0;
   logic [DATA_W-1:0]       csr_data = '0;

   logic                    req_busy, csr_ready, rsp_valid, rsp_parallel_error;
   logic signed [POS_W-1:0] rsp_drifted_entry_x, rsp_drifted_entry_y;
   logic signed [POS_W-1:0] rsp_drifted_exit_x, rsp_drifted_exit_y;
   logic signed [POS_W-1:0] rsp_entry_x, rsp_entry_y, rsp_entry_z;
   logic signed [POS_W-1:0] rsp_exit_x, rsp_exit_y, rsp_exit_z;
   int                      failures, pending;
   int                      quiet_cycles = 0;

   always #5 clock = ~clock;

   planar_hit_drift_projection dut (.*);
   planar_hit_drift_projection_checker checker_i (.*);

   // watchdog: a stuck block shows up as a long stretch with no transfer
   always @(posedge clock) begin
      if (reset || (req_start && !req_busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [DATA_W-1:0] pack3(int x, int y, int z);
      return {z[15:0], y[15:0], x[15:0]};
   endfunction

   task automatic write_reg(reg_index_type idx, logic [DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_geometry(logic [ROW_W-1:0] rx, logic [ROW_W-1:0] ry,
                               logic [ROW_W-1:0] rz, int ox, int oy, int oz,
                               int thick, logic [ROW_W-1:0] drift);
      write_reg(REG_ROT_ROW_X, rx);
      write_reg(REG_ROT_ROW_Y, ry);
      write_reg(REG_ROT_ROW_Z, rz);
      write_reg(REG_ORIGIN_X, 48'(ox));
      write_reg(REG_ORIGIN_Y, 48'(oy));
      write_reg(REG_ORIGIN_Z, 48'(oz));
      write_reg(REG_THICKNESS, 48'(thick));
      write_reg(REG_DRIFT, drift);
   endtask

   // start stays high across back-to-back transfers; a gap lowers it
   task automatic send_hit(int px, int py, int pz, int dx, int dy, int dz, int idle_pct);
      req_pos_x <= px[POS_W-1:0];
      req_pos_y <= py[POS_W-1:0];
      req_pos_z <= pz[POS_W-1:0];
      req_dir_x <= dx[DIR_W-1:0];
      req_dir_y <= dy[DIR_W-1:0];
      req_dir_z <= dz[DIR_W-1:0];
      req_start <= 1'b1;
      do @(posedge clock); while (req_busy);
      if ($urandom_range(99) < idle_pct) begin
         req_start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // hold off until every result is in, then let the pipe empty
   task automatic drain();
      req_start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_hit(int idle_pct);
      int px, py, pz, dx, dy, dz, kind;
      kind = $urandom_range(9);
      px = $urandom; py = $urandom; pz = $urandom;
      dx = $urandom; dy = $urandom; dz = $urandom;
      if (kind >= 2) begin
         // typical track: clear z crossing; kinds below 8 also get a moderate position
         if (kind < 8) begin
            px = int'($signed(px[20:0]));
            py = int'($signed(py[20:0]));
            pz = int'($signed(pz[20:0]));
         end
         dx = int'($signed(dx[14:0]));
         dy = int'($signed(dy[14:0]));
         dz = $urandom_range(4000, 32767);
         if (kind[0]) begin
            dz = -dz;
         end
      end else if (kind == 1) begin
         // grazing track near the parallel threshold
         dz = $urandom_range(0, 4) - 2;
      end
      send_hit(px, py, pz, dx, dy, dz, idle_pct);
   endtask

   initial begin
      int idle_pct;
      logic [ROW_W-1:0] ident_x, ident_y, ident_z;
      ident_x = pack3(16384, 0, 0);
      ident_y = pack3(0, 16384, 0);
      ident_z = pack3(0, 0, 16384);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed hits under the reset geometry
      send_hit(0, 0, 0, 0, 0, 16384, 0);
      send_hit(8388607, 8388607, 8388607, 0, 0, 16384, 0);
      send_hit(-8388608, -8388608, -8388608, 0, 0, -16384, 0);
      send_hit(1000, -1000, 500, 32767, 32767, 32767, 0);
      send_hit(-5, 7, 3, -32768, -32768, -32768, 0);
      send_hit(0, 0, 0, 0, 0, 0, 0);                 // null direction
      send_hit(100, 200, 300, 16384, 0, 0, 0);       // z part exactly zero
      send_hit(100, 200, 300, 32767, 32767, 1, 0);   // grazing, below threshold
      send_hit(100, 200, 300, 0, 0, 1, 0);           // tiny but straight through
      send_hit(8388607, -8388608, 0, 32767, -32768, 1, 0); // grazing, below threshold: flagged parallel
      send_hit(12345, -6789, 4321, 3000, -2000, 16000, 0);
      drain();

      // drift on, then each register extreme
      set_geometry(ident_x, ident_y, ident_z, 0, 0, 0, 307, pack3(3000, -2000, 16000));
      send_hit(0, 0, 0, 0, 0, 16384, 0);
      send_hit(8388607, 8388607, 0, 0, 0, 16384, 0);
      send_hit(-8388608, -8388608, 0, 100, 100, -16384, 0);
      drain();
      set_geometry({3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}}, 8388607, 8388607,
                   8388607, 65535, pack3(32767, -32768, 2));
      send_hit(-8388608, -8388608, -8388608, 32767, 32767, 32767, 0);
      send_hit(8388607, 0, -8388608, -32768, 32767, -32768, 0);
      send_hit(0, 0, 0, 1, 1, 1, 0);
      drain();
      set_geometry(ident_z, ident_y, ident_x, -8388608, -8388608, -8388608, 0,
                   pack3(0, 0, -16384));
      send_hit(8388607, 8388607, 8388607, 16384, 0, 100, 0);
      send_hit(0, 0, 0, -16384, 5, 3, 0);
      drain();

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: set_geometry(ident_x, ident_y, ident_z, 0, 0, 0, 307,
                            pack3(2000, 1500, -15000));
            1: set_geometry(pack3(0, 16384, 0), pack3(-16384, 0, 0), ident_z,
                            1024, -2048, 4096, 65535, pack3(1, 0, 1));  // drift below eps
            2: set_geometry({3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}},
                            -8388608, 8388607, -8388608, 0, pack3(-32768, 32767, -32768));
            3: set_geometry(ident_x, ident_y, ident_z, 0, 0, 0, 614,
                            pack3(1, 1, 2));  // drift just above eps
            default: set_geometry(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                  48'({$urandom, $urandom}),
                                  int'($signed(24'($urandom))),
                                  int'($signed(24'($urandom))),
                                  int'($signed(24'($urandom))),
                                  $urandom_range(65535), 48'({$urandom, $urandom}));
         endcase
         for (int n = 0; n < PHASE_HITS; n++) begin
            case ((n / 50) % 4)
               0: idle_pct = 0;
               1: idle_pct = 65;
               2: idle_pct = 0;
               default: idle_pct = 16;
            endcase
            random_hit(idle_pct);
         end
         drain();
      end

      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
